// ----- sv/ooktx_pkg.sv -----
// Shared constants, register codes and types of the on-off-keyed pulse table transmitter.
`timescale 1ns / 1ps
`default_nettype none
package ooktx_pkg;

   localparam int MAX_SYMBOLS   = 128;
   localparam int TABLE_ENTRIES = 6;
   localparam int DUR_REGS      = 6;
   localparam int DUR_W         = 15;
   localparam int RPT_W         = 4;
   localparam int TICK_W        = 14;
   localparam int SYM_W         = 3;
   localparam int FUNC_W        = 2;
   localparam int CSR_IDX_W     = 3;

   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DUR_0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT = 3'd6;

   // Symbols at or above this limit are rejected on load.
   localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(TABLE_ENTRIES);

   localparam logic [DUR_REGS-1:0][DUR_W-1:0] DUR_RESET =
      {15'h7CB8, 15'h0118, 15'h7EE8, 15'h0230, 15'h7A88, 15'h1298};
   localparam logic [RPT_W-1:0]  RPT_RESET = 4'd10;
   localparam logic [TICK_W-1:0] TICK_MAX  = '1;

   typedef struct packed {
      logic [DUR_REGS-1:0][DUR_W-1:0] dur;
      logic [RPT_W-1:0]               repeat_count;
   } cfg_type;

endpackage
`default_nettype wire

// ----- sv/ooktx_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ooktx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- sv/ooktx_csr.sv -----
// Configuration registers: the pulse duration table and the repeat count.
`timescale 1ns / 1ps
`default_nettype none
module ooktx_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wen,
   input  wire logic [ooktx_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ooktx_pkg::DUR_W-1:0]         csr_wdata,
   output ooktx_pkg::cfg_type                       cfg
);

   ooktx_pkg::cfg_type cfg_ff;
   ooktx_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         for (int i = 0; i < ooktx_pkg::DUR_REGS; i++) begin
            if (csr_index == ooktx_pkg::CSR_DUR_0 + ooktx_pkg::CSR_IDX_W'(i)) begin
               cfg_in.dur[i] = csr_wdata;
            end
         end
         if (csr_index == ooktx_pkg::CSR_REPEAT) begin
            cfg_in.repeat_count = csr_wdata[ooktx_pkg::RPT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dur          <= ooktx_pkg::DUR_RESET;
         cfg_ff.repeat_count <= ooktx_pkg::RPT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- sv/ooktx_seq.sv -----
// Sequencer: handles each word, drives the symbol store and shapes the pin waveform.
`timescale 1ns / 1ps
`default_nettype none
module ooktx_seq #(
   parameter int MAX_SYMBOLS = ooktx_pkg::MAX_SYMBOLS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ooktx_pkg::cfg_type                 cfg,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [ooktx_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [ooktx_pkg::SYM_W-1:0]        req_symbol,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_pin_level,
   output logic                                    rsp_busy_res,
   output logic                                    rsp_done_res,
   output logic                                    rsp_error,
   output logic                                    ram_we,
   output logic [$clog2(MAX_SYMBOLS)-1:0]          ram_waddr,
   output logic [ooktx_pkg::SYM_W-1:0]             ram_wdata,
   output logic [$clog2(MAX_SYMBOLS)-1:0]          ram_raddr,
   input  wire logic [ooktx_pkg::SYM_W-1:0]        ram_rdata
);

   localparam int AW = $clog2(MAX_SYMBOLS);
   localparam int CW = $clog2(MAX_SYMBOLS + 1);
   localparam int TW = ooktx_pkg::TICK_W;
   localparam int RW = ooktx_pkg::RPT_W;
   localparam int DW = ooktx_pkg::DUR_W;

   localparam logic ST_ACCEPT = 1'b0;
   localparam logic ST_FINISH = 1'b1;

   logic          state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [RW-1:0] rep_ff, rep_in;
   logic [TW-1:0] ticks_ff, ticks_in;
   logic          sending_ff, sending_in;
   logic          level_ff, level_in;
   logic          pin_new_ff, pin_new_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_pin_ff, rsp_pin_in;
   logic          rsp_busy_ff, rsp_busy_in;
   logic          rsp_done_ff, rsp_done_in;
   logic          rsp_err_ff, rsp_err_in;

   logic          accept;
   logic          begin_pulse;
   logic [TW-1:0] ticks_dec;
   logic [CW-1:0] pos_inc;
   logic [RW-1:0] rep_dec;
   logic [DW-1:0] dur;
   logic [DW-1:0] mag;
   logic          lvl_new;
   logic [TW-1:0] ticks_new;

   assign req_stall = (state_ff == ST_FINISH) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign ticks_dec = (ticks_ff == '0) ? '0 : ticks_ff - 1'b1;
   assign pos_inc   = CW'(pos_ff) + 1'b1;
   assign rep_dec   = (rep_ff == '0) ? '0 : rep_ff - 1'b1;

   // Pulse set-up from the symbol read out of the store.
   always_comb begin
      dur = '0;
      for (int i = 0; i < ooktx_pkg::DUR_REGS; i++) begin
         if (ram_rdata == ooktx_pkg::SYM_W'(i)) begin
            dur = cfg.dur[i];
         end
      end
      lvl_new = !dur[DW-1];
      mag     = dur[DW-1] ? (~dur + 1'b1) : dur;
      if (mag > DW'(ooktx_pkg::TICK_MAX)) begin
         ticks_new = ooktx_pkg::TICK_MAX;
      end else if (mag == '0) begin
         ticks_new = TW'(1);
      end else begin
         ticks_new = mag[TW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      rep_in       = rep_ff;
      ticks_in     = ticks_ff;
      sending_in   = sending_ff;
      level_in     = level_ff;
      pin_new_in   = pin_new_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pin_in   = rsp_pin_ff;
      rsp_busy_in  = rsp_busy_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_err_in   = rsp_err_ff;
      ram_we       = 1'b0;
      ram_raddr    = '0;
      begin_pulse  = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_ACCEPT: begin
            if (accept) begin
               rsp_pin_in  = level_ff;
               rsp_done_in = 1'b0;
               rsp_err_in  = 1'b0;
               pin_new_in  = 1'b0;
               priority if (req_func == ooktx_pkg::FUNC_TICK) begin
                  if (sending_ff) begin
                     ticks_in = ticks_dec;
                     if (ticks_dec == '0) begin
                        if (pos_inc >= count_ff) begin
                           rep_in = rep_dec;
                           pos_in = '0;
                           if (rep_dec == '0) begin
                              sending_in  = 1'b0;
                              level_in    = 1'b0;
                              rsp_done_in = 1'b1;
                           end else begin
                              begin_pulse = 1'b1;
                           end
                        end else begin
                           pos_in      = pos_inc[AW-1:0];
                           ram_raddr   = pos_inc[AW-1:0];
                           begin_pulse = 1'b1;
                        end
                     end
                  end
               end else if (sending_ff) begin
                  rsp_err_in = 1'b1;
               end else if (req_func == ooktx_pkg::FUNC_LOAD) begin
                  if ({1'b0, req_symbol} >= ooktx_pkg::SYM_LIMIT
                      || count_ff >= CW'(MAX_SYMBOLS)) begin
                     rsp_err_in = 1'b1;
                  end else begin
                     ram_we   = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else if (req_func == ooktx_pkg::FUNC_START) begin
                  if (count_ff == '0) begin
                     rsp_err_in = 1'b1;
                  end else begin
                     rep_in      = (cfg.repeat_count == '0) ? RW'(1) : cfg.repeat_count;
                     pos_in      = '0;
                     sending_in  = 1'b1;
                     pin_new_in  = 1'b1;
                     begin_pulse = 1'b1;
                  end
               end else begin
                  count_in = '0;
               end
               rsp_busy_in = sending_in;
               if (begin_pulse) begin
                  state_in = ST_FINISH;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            level_in = lvl_new;
            ticks_in = ticks_new;
            if (pin_new_ff) begin
               rsp_pin_in = lvl_new;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_ACCEPT;
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   assign ram_waddr = count_ff[AW-1:0];
   assign ram_wdata = req_symbol;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         count_ff     <= '0;
         pos_ff       <= '0;
         rep_ff       <= '0;
         ticks_ff     <= '0;
         sending_ff   <= 1'b0;
         level_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rep_ff       <= rep_in;
         ticks_ff     <= ticks_in;
         sending_ff   <= sending_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pin_new_ff  <= pin_new_in;
      rsp_pin_ff  <= rsp_pin_in;
      rsp_busy_ff <= rsp_busy_in;
      rsp_done_ff <= rsp_done_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pin_level = rsp_pin_ff;
   assign rsp_busy_res  = rsp_busy_ff;
   assign rsp_done_res  = rsp_done_ff;
   assign rsp_error     = rsp_err_ff;

endmodule
`default_nettype wire

// ----- sv/ook_pulse_table_transmitter.sv -----
// A result word is registered in the cycle after its request word is accepted; a word that
// starts a pulse (a start, or a tick that ends a pulse) first goes to ST_FINISH, since the
// next symbol must come out of the symbol store's registered read before the pulse is set up.
// Throughput: one word per cycle while results are not stalled and no pulse is being set up.
// Reset is synchronous and active high: it clears the control state and restores the
// duration table and repeat count; the symbol store is not cleared and has no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module ook_pulse_table_transmitter #(
   parameter int MAX_SYMBOLS = ooktx_pkg::MAX_SYMBOLS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wen,
   input  wire logic [ooktx_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ooktx_pkg::DUR_W-1:0]      csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [ooktx_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [ooktx_pkg::SYM_W-1:0]      req_symbol,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_pin_level,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic                                  rsp_error
);

   localparam int AW = $clog2(MAX_SYMBOLS);

   ooktx_pkg::cfg_type              cfg;
   logic                            ram_we;
   logic [AW-1:0]                   ram_waddr;
   logic [ooktx_pkg::SYM_W-1:0]     ram_wdata;
   logic [AW-1:0]                   ram_raddr;
   logic [ooktx_pkg::SYM_W-1:0]     ram_rdata;

   ooktx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ooktx_ram #(
      .WIDTH (ooktx_pkg::SYM_W),
      .DEPTH (MAX_SYMBOLS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ooktx_seq #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_symbol    (req_symbol),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pin_level (rsp_pin_level),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_error     (rsp_error),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata)
   );

endmodule
`default_nettype wire

// ----- test/ook_pulse_table_transmitter_test.sv -----
// Self-checking testbench of the on-off-keyed pulse table transmitter, built around a scoreboard.
`timescale 1ns / 1ps
module ook_pulse_table_transmitter_test;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_WORDS  = 400;
   localparam int IDLE_PERCENT  = 38;
   localparam int REPORT_LIMIT  = 100;
   localparam int TICK_LIMIT    = (1 << ooktx_pkg::TICK_W) - 1;

   localparam logic [ooktx_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   // Short durations of both signs, including zero and minus one.
   localparam logic [ooktx_pkg::DUR_REGS-1:0][ooktx_pkg::DUR_W-1:0] DIRECTED_DURS =
      {15'h7FFD, 15'h0001, 15'h7FFE, 15'h0002, 15'h7FFF, 15'h0000};

   typedef struct packed {
      logic pin_level;
      logic busy;
      logic done;
      logic rejected;
   } tx_status_type;

   class pin_waveform_tracker;
      logic signed [ooktx_pkg::DUR_W-1:0] dur [ooktx_pkg::DUR_REGS];
      logic [ooktx_pkg::RPT_W-1:0]        repeat_count;
      logic [ooktx_pkg::SYM_W-1:0]        store [ooktx_pkg::MAX_SYMBOLS];
      int                                 symbol_count;
      int                                 position;
      int                                 repeats_left;
      int                                 ticks_left;
      bit                                 sending;
      logic                               level;
      tx_status_type                      expected_status [$];
      int                                 failures;

      function new();
         dur[0] = 15'sd4760;
         dur[1] = -15'sd1400;
         dur[2] = 15'sd560;
         dur[3] = -15'sd280;
         dur[4] = 15'sd280;
         dur[5] = -15'sd840;
         repeat_count = 4'd10;
         symbol_count = 0;
         position = 0;
         repeats_left = 0;
         ticks_left = 0;
         sending = 1'b0;
         level = 1'b0;
         failures = 0;
      endfunction

      function void write_register(logic [ooktx_pkg::CSR_IDX_W-1:0] index,
                                   logic [ooktx_pkg::DUR_W-1:0] data);
         if (index < ooktx_pkg::DUR_REGS) begin
            dur[index] = data;
         end else if (index == ooktx_pkg::CSR_REPEAT) begin
            repeat_count = data[ooktx_pkg::RPT_W-1:0];
         end
      endfunction

      function void start_pulse();
         logic [ooktx_pkg::SYM_W-1:0] sym;
         int span;
         sym = (position < ooktx_pkg::MAX_SYMBOLS) ? store[position] : '0;
         span = (sym < ooktx_pkg::DUR_REGS) ? int'(dur[sym]) : 0;
         level = (span >= 0);
         if (span < 0) span = -span;
         if (span > TICK_LIMIT) span = TICK_LIMIT;
         if (span == 0) span = 1;
         ticks_left = span;
      endfunction

      // Returns one when the word changed the state of the transmitter.
      function bit note_word(logic [ooktx_pkg::FUNC_W-1:0] func,
                             logic [ooktx_pkg::SYM_W-1:0] sym);
         tx_status_type status;
         bit effect;
         status = '0;
         status.pin_level = level;
         effect = 1'b1;
         if (func == ooktx_pkg::FUNC_TICK) begin
            effect = sending;
            if (sending) begin
               if (ticks_left > 0) ticks_left--;
               if (ticks_left == 0) begin
                  position++;
                  if (position >= symbol_count) begin
                     if (repeats_left > 0) repeats_left--;
                     if (repeats_left == 0) begin
                        sending = 1'b0;
                        level = 1'b0;
                        position = 0;
                        status.done = 1'b1;
                     end else begin
                        position = 0;
                        start_pulse();
                     end
                  end else begin
                     start_pulse();
                  end
               end
            end
         end else if (sending
                      || (func == ooktx_pkg::FUNC_LOAD
                          && (sym >= ooktx_pkg::TABLE_ENTRIES
                              || symbol_count >= ooktx_pkg::MAX_SYMBOLS))
                      || (func == ooktx_pkg::FUNC_START && symbol_count == 0)) begin
            status.rejected = 1'b1;
            effect = 1'b0;
         end else begin
            case (func)
               ooktx_pkg::FUNC_LOAD: begin
                  store[symbol_count] = sym;
                  symbol_count++;
               end
               ooktx_pkg::FUNC_START: begin
                  repeats_left = (repeat_count == 0) ? 1 : int'(repeat_count);
                  position = 0;
                  sending = 1'b1;
                  start_pulse();
                  status.pin_level = level;
               end
               default: begin
                  symbol_count = 0;
               end
            endcase
         end
         status.busy = sending;
         expected_status.push_back(status);
         return effect;
      endfunction

      function void compare_field(string name, logic want, logic got);
         if (got !== want) begin
            if (failures < REPORT_LIMIT)
               $display("%0t: %s expected %0b, actual %0b", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_word(tx_status_type got);
         tx_status_type want;
         if (expected_status.size() == 0) begin
            if (failures < REPORT_LIMIT)
               $display("%0t: word expected none, actual pin %0b busy %0b done %0b error %0b",
                        $time, got.pin_level, got.busy, got.done, got.rejected);
            failures++;
         end else begin
            want = expected_status.pop_front();
            compare_field("pin level", want.pin_level, got.pin_level);
            compare_field("busy", want.busy, got.busy);
            compare_field("done", want.done, got.done);
            compare_field("error", want.rejected, got.rejected);
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              csr_wen;
   logic [ooktx_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [ooktx_pkg::DUR_W-1:0]       csr_wdata;
   logic                              req_valid;
   logic                              req_stall;
   logic [ooktx_pkg::FUNC_W-1:0]      req_func;
   logic [ooktx_pkg::SYM_W-1:0]       req_symbol;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic                              rsp_pin_level;
   logic                              rsp_busy_res;
   logic                              rsp_done_res;
   logic                              rsp_error;

   pin_waveform_tracker tracker;
   int idle_percent = IDLE_PERCENT;
   int stall_percent = IDLE_PERCENT;
   int effective_words = 0;
   int cycle_count = 0;

   ook_pulse_table_transmitter dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_symbol    (req_symbol),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pin_level (rsp_pin_level),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_error     (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin : cycle_watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : response_side
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            tracker.check_word(tx_status_type'({rsp_pin_level, rsp_busy_res, rsp_done_res,
                                                rsp_error}));
         rsp_stall <= (stall_percent != 0) && ($urandom_range(99) < stall_percent);
      end
   end

   task automatic send_word(input logic [ooktx_pkg::FUNC_W-1:0] func,
                            input logic [ooktx_pkg::SYM_W-1:0] sym);
      while (idle_percent != 0 && $urandom_range(99) < idle_percent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_symbol <= sym;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (tracker.note_word(func, sym)) effective_words++;
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (tracker.expected_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [ooktx_pkg::CSR_IDX_W-1:0] index,
                                 input logic [ooktx_pkg::DUR_W-1:0] data);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_register(index, data);
   endtask

   task automatic program_registers(
      input logic [ooktx_pkg::DUR_REGS-1:0][ooktx_pkg::DUR_W-1:0] durations,
      input logic [ooktx_pkg::RPT_W-1:0] repeats);
      wait_until_idle();
      for (int k = 0; k < ooktx_pkg::DUR_REGS; k++)
         write_register(ooktx_pkg::CSR_DUR_0 + ooktx_pkg::CSR_IDX_W'(k), durations[k]);
      write_register(ooktx_pkg::CSR_REPEAT, ooktx_pkg::DUR_W'(repeats));
      write_register(CSR_UNUSED, ooktx_pkg::DUR_W'($urandom));
      csr_wen <= 1'b0;
   endtask

   function automatic logic [ooktx_pkg::DUR_W-1:0] short_duration();
      int span;
      span = int'($urandom_range(12)) - 6;
      return span[ooktx_pkg::DUR_W-1:0];
   endfunction

   function automatic logic [ooktx_pkg::SYM_W-1:0] load_symbol();
      if ($urandom_range(9) == 0) return ooktx_pkg::SYM_W'($urandom_range(7));
      return ooktx_pkg::SYM_W'($urandom_range(ooktx_pkg::TABLE_ENTRIES - 1));
   endfunction

   task automatic finish_transmission(input bit noisy);
      while (tracker.sending) begin
         if (noisy && $urandom_range(15) == 0)
            send_word(ooktx_pkg::FUNC_W'($urandom_range(3)),
                      ooktx_pkg::SYM_W'($urandom_range(7)));
         else
            send_word(ooktx_pkg::FUNC_TICK, ooktx_pkg::SYM_W'($urandom_range(7)));
      end
   endtask

   task automatic random_transmission();
      logic [ooktx_pkg::DUR_REGS-1:0][ooktx_pkg::DUR_W-1:0] durations;
      int loads;
      for (int k = 0; k < ooktx_pkg::DUR_REGS; k++) durations[k] = short_duration();
      program_registers(durations,
                        ($urandom_range(9) == 0) ? 4'd15
                                                 : ooktx_pkg::RPT_W'($urandom_range(3)));
      if ($urandom_range(3) != 0)
         send_word(ooktx_pkg::FUNC_CLEAR, ooktx_pkg::SYM_W'($urandom_range(7)));
      loads = $urandom_range(1, 8);
      repeat (loads) begin
         if ($urandom_range(11) == 0)
            send_word(ooktx_pkg::FUNC_W'($urandom_range(3)),
                      ooktx_pkg::SYM_W'($urandom_range(7)));
         else
            send_word(ooktx_pkg::FUNC_LOAD, load_symbol());
      end
      send_word(ooktx_pkg::FUNC_START, ooktx_pkg::SYM_W'($urandom_range(7)));
      finish_transmission(1'b1);
      repeat ($urandom_range(2))
         send_word(ooktx_pkg::FUNC_TICK, ooktx_pkg::SYM_W'($urandom_range(7)));
   endtask

   initial begin : stimulus
      logic [ooktx_pkg::DUR_REGS-1:0][ooktx_pkg::DUR_W-1:0] durations;
      tracker = new();
      reset <= 1'b1;
      csr_wen <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_func <= ooktx_pkg::FUNC_TICK;
      req_symbol <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Idle tick, start on an empty store, invalid symbols, then words while busy.
      send_word(ooktx_pkg::FUNC_TICK, 3'd7);
      send_word(ooktx_pkg::FUNC_START, 3'd0);
      send_word(ooktx_pkg::FUNC_LOAD, 3'd6);
      send_word(ooktx_pkg::FUNC_LOAD, 3'd7);
      send_word(ooktx_pkg::FUNC_LOAD, 3'd4);
      wait_until_idle();
      write_register(ooktx_pkg::CSR_REPEAT, ooktx_pkg::DUR_W'(1));
      csr_wen <= 1'b0;
      send_word(ooktx_pkg::FUNC_START, 3'd5);
      send_word(ooktx_pkg::FUNC_LOAD, 3'd0);
      send_word(ooktx_pkg::FUNC_START, 3'd0);
      send_word(ooktx_pkg::FUNC_CLEAR, 3'd0);
      finish_transmission(1'b0);

      program_registers(DIRECTED_DURS, 4'd0);
      send_word(ooktx_pkg::FUNC_CLEAR, 3'd2);
      for (int k = 0; k < ooktx_pkg::TABLE_ENTRIES; k++)
         send_word(ooktx_pkg::FUNC_LOAD, ooktx_pkg::SYM_W'(k));
      send_word(ooktx_pkg::FUNC_START, 3'd0);
      finish_transmission(1'b0);

      // Fill the store completely, then overflow it, with no idling on either side.
      for (int k = 0; k < ooktx_pkg::DUR_REGS; k++) durations[k] = short_duration();
      program_registers(durations, 4'd1);
      idle_percent = 0;
      stall_percent = 0;
      send_word(ooktx_pkg::FUNC_CLEAR, 3'd0);
      repeat (ooktx_pkg::MAX_SYMBOLS)
         send_word(ooktx_pkg::FUNC_LOAD,
                   ooktx_pkg::SYM_W'($urandom_range(ooktx_pkg::TABLE_ENTRIES - 1)));
      send_word(ooktx_pkg::FUNC_LOAD, 3'd1);
      send_word(ooktx_pkg::FUNC_START, 3'd0);
      finish_transmission(1'b1);
      idle_percent = IDLE_PERCENT;
      stall_percent = IDLE_PERCENT;

      effective_words = 0;
      while (effective_words < RANDOM_WORDS) random_transmission();

      wait_until_idle();
      if (tracker.failures == 0 && tracker.expected_status.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
